// ----- design/running_median_two_heaps_top_macros.svh -----
// assertion macros for the running median block
`ifndef RUNNING_MEDIAN_TWO_HEAPS_TOP_MACROS_SVH
`define RUNNING_MEDIAN_TWO_HEAPS_TOP_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define RMH_ASSERT_IMPL(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error(msg);

// implication whose consequent is checked in the next cycle
`define RMH_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error(msg);

`endif

// ----- design/rmh_pkg.sv -----
package rmh_pkg;

  localparam int unsigned HEAP_DEPTH_DEF  = 512;
  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned QUEUE_DEPTH     = 2;

  // what the front part decided for one word
  typedef enum logic [2:0] {
    OP_PUSH_UP,    // push sample to upper, median is new upper top
    OP_PUSH_LO,    // push sample to lower, median is new lower top
    OP_UP_MEAN,    // push sample to upper, median is mean of tops
    OP_LO_MEAN,    // push sample to lower, median is mean of tops
    OP_MV_LO_UP,   // move lower top to upper, swap sample into lower, mean
    OP_MV_UP_LO,   // move upper top to lower, swap sample into upper, mean
    OP_OVERFLOW    // dropped
  } op_t;

endpackage

// ----- design/rmh_stream_if.sv -----
interface rmh_stream_if #(
  parameter int unsigned SAMPLE_BITS = rmh_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          start_new;
  logic signed [SAMPLE_BITS-1:0] median_out;
  logic                          overflow;

  modport source (output valid, sample, start_new, median_out, overflow, input ready);
  modport sink (input valid, sample, start_new, median_out, overflow, output ready);
endinterface

// ----- design/rmh_heap.sv -----
// one heap in a memory, max or min; clear, push, replace top (pop then push)
module rmh_heap #(
  parameter int unsigned HEAP_DEPTH  = rmh_pkg::HEAP_DEPTH_DEF,
  parameter int unsigned SAMPLE_BITS = rmh_pkg::SAMPLE_BITS_DEF,
  parameter bit          IS_MAX      = 1'b1,
  localparam int unsigned AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1,
  localparam int unsigned CW = $clog2(HEAP_DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          clear,
  input  logic                          push,
  input  logic                          replace,
  input  logic signed [SAMPLE_BITS-1:0] value,
  output logic                          busy,
  output logic signed [SAMPLE_BITS-1:0] top,
  output logic [CW-1:0]                 count
);

  typedef enum logic [2:0] {
    S_IDLE, S_UP_RD, S_UP_CMP, S_DN_RD, S_DN_RD2, S_DN_CMP
  } state_t;

  logic signed [SAMPLE_BITS-1:0] mem [HEAP_DEPTH];
  state_t                        state;
  logic [AW-1:0]                 pos;
  logic signed [SAMPLE_BITS-1:0] val;
  logic signed [SAMPLE_BITS-1:0] rd_data;
  logic signed [SAMPLE_BITS-1:0] lch;
  logic [AW-1:0]                 rd_addr;
  logic                          wr_en;
  logic [AW-1:0]                 wr_addr;
  logic signed [SAMPLE_BITS-1:0] wr_data;
  logic [CW:0]                   lidx;
  logic [CW:0]                   ridx;
  logic [AW-1:0]                 parent;
  logic                          l_ok;
  logic                          r_ok;
  logic                          r_better;
  logic signed [SAMPLE_BITS-1:0] best;
  logic [AW-1:0]                 best_idx;

  function automatic logic above(input logic signed [SAMPLE_BITS-1:0] a,
                                 input logic signed [SAMPLE_BITS-1:0] b);
    above = IS_MAX ? (a > b) : (a < b);
  endfunction

  assign busy   = (state != S_IDLE);
  assign parent = AW'((pos - AW'(1)) >> 1);
  assign lidx   = (CW+1)'({pos, 1'b1});
  assign ridx   = lidx + (CW+1)'(1);
  assign l_ok   = lidx < (CW+1)'(count);
  assign r_ok   = ridx < (CW+1)'(count);
  assign r_better = r_ok && above(rd_data, lch);
  assign best     = r_better ? rd_data : lch;
  assign best_idx = r_better ? ridx[AW-1:0] : lidx[AW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_comb begin
    rd_addr = parent;
    wr_en   = 1'b0;
    wr_addr = pos;
    wr_data = val;
    case (state)
      S_UP_RD:  rd_addr = parent;
      S_DN_RD:  rd_addr = lidx[AW-1:0];
      S_DN_RD2: rd_addr = ridx[AW-1:0];
      S_UP_CMP: begin
        if (pos != '0 && above(val, rd_data)) begin
          wr_en = 1'b1;
          wr_addr = pos;
          wr_data = rd_data;
        end else begin
          wr_en = 1'b1;
        end
      end
      S_DN_CMP: begin
        if (l_ok && above(best, val)) begin
          wr_en = 1'b1;
          wr_data = best;
        end else begin
          wr_en = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (clear) begin
            count <= '0;
          end else if (push) begin
            pos   <= AW'(count);
            val   <= value;
            count <= count + CW'(1);
            state <= S_UP_RD;
          end else if (replace) begin
            pos   <= '0;
            val   <= value;
            state <= S_DN_RD;
          end
        end
        S_UP_RD: begin
          state <= S_UP_CMP;
        end
        S_UP_CMP: begin
          if (pos != '0 && above(val, rd_data)) begin
            pos   <= parent;
            state <= S_UP_RD;
          end else begin
            if (pos == '0) top <= val;
            state <= S_IDLE;
          end
        end
        S_DN_RD: begin
          state <= S_DN_RD2;
        end
        S_DN_RD2: begin
          lch   <= rd_data;
          state <= S_DN_CMP;
        end
        S_DN_CMP: begin
          if (l_ok && above(best, val)) begin
            if (pos == '0) top <= best;
            pos   <= best_idx;
            state <= S_DN_RD;
          end else begin
            if (pos == '0) top <= val;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- design/rmh_front.sv -----
// classifies words against the median the back part will leave; tracks counts
module rmh_front #(
  parameter int unsigned HEAP_DEPTH  = rmh_pkg::HEAP_DEPTH_DEF,
  parameter int unsigned SAMPLE_BITS = rmh_pkg::SAMPLE_BITS_DEF,
  localparam int unsigned CW = $clog2(HEAP_DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  rmh_stream_if.sink                    in_ch,
  input  logic                          back_idle,
  input  logic signed [SAMPLE_BITS-1:0] median,
  output logic                          q_valid,
  output rmh_pkg::op_t                  q_op,
  output logic                          q_clear,
  output logic signed [SAMPLE_BITS-1:0] q_sample,
  input  logic                          q_ready
);

  logic [CW-1:0]                 lo_cnt;
  logic [CW-1:0]                 up_cnt;
  logic [CW-1:0]                 lo_cnt_next;
  logic [CW-1:0]                 up_cnt_next;
  logic signed [SAMPLE_BITS-1:0] base;
  logic                          goes_up;
  logic                          full_lo;
  logic                          full_up;
  rmh_pkg::op_t                  op;

  // the median depends on the previous item, so one item in flight at a time
  assign in_ch.ready = q_ready && back_idle;

  always_comb begin
    lo_cnt_next = in_ch.start_new ? '0 : lo_cnt;
    up_cnt_next = in_ch.start_new ? '0 : up_cnt;
    base = in_ch.start_new ? '0 : median;
    goes_up = in_ch.sample > base;
    full_lo = lo_cnt_next >= CW'(HEAP_DEPTH);
    full_up = up_cnt_next >= CW'(HEAP_DEPTH);
    if (lo_cnt_next == up_cnt_next) begin
      if (goes_up) op = full_up ? rmh_pkg::OP_OVERFLOW : rmh_pkg::OP_PUSH_UP;
      else         op = full_lo ? rmh_pkg::OP_OVERFLOW : rmh_pkg::OP_PUSH_LO;
    end else if (lo_cnt_next > up_cnt_next) begin
      if (full_up)      op = rmh_pkg::OP_OVERFLOW;
      else if (goes_up) op = rmh_pkg::OP_UP_MEAN;
      else              op = rmh_pkg::OP_MV_LO_UP;
    end else begin
      if (full_lo)      op = rmh_pkg::OP_OVERFLOW;
      else if (goes_up) op = rmh_pkg::OP_MV_UP_LO;
      else              op = rmh_pkg::OP_LO_MEAN;
    end
  end

  assign q_valid  = in_ch.valid && in_ch.ready;
  assign q_op     = op;
  assign q_clear  = in_ch.start_new;
  assign q_sample = in_ch.sample;

  always_ff @(posedge clk) begin
    if (rst) begin
      lo_cnt <= '0;
      up_cnt <= '0;
    end else if (q_valid) begin
      lo_cnt <= lo_cnt_next;
      up_cnt <= up_cnt_next;
      case (op)
        rmh_pkg::OP_PUSH_UP, rmh_pkg::OP_UP_MEAN, rmh_pkg::OP_MV_LO_UP:
          up_cnt <= up_cnt_next + CW'(1);
        rmh_pkg::OP_PUSH_LO, rmh_pkg::OP_LO_MEAN, rmh_pkg::OP_MV_UP_LO:
          lo_cnt <= lo_cnt_next + CW'(1);
        default: ;
      endcase
    end
  end

endmodule

// ----- design/rmh_back.sv -----
// runs heap operations for one queued word and produces the result
module rmh_back #(
  parameter int unsigned HEAP_DEPTH  = rmh_pkg::HEAP_DEPTH_DEF,
  parameter int unsigned SAMPLE_BITS = rmh_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  rmh_pkg::op_t                  q_op,
  input  logic                          q_clear,
  input  logic signed [SAMPLE_BITS-1:0] q_sample,
  output logic                          q_ready,
  output logic                          idle,
  output logic signed [SAMPLE_BITS-1:0] median,
  rmh_stream_if.source                  out_ch
);

  typedef enum logic [2:0] {S_TAKE, S_OP1, S_WAIT1, S_OP2, S_WAIT2, S_RES, S_OUT}
    state_t;
  localparam int unsigned CW = $clog2(HEAP_DEPTH + 1);

  // queue of depth QUEUE_DEPTH between front and back
  rmh_pkg::op_t                  qo   [rmh_pkg::QUEUE_DEPTH];
  logic                          qc   [rmh_pkg::QUEUE_DEPTH];
  logic signed [SAMPLE_BITS-1:0] qs   [rmh_pkg::QUEUE_DEPTH];
  logic                          qwp;
  logic                          qrp;
  logic [1:0]                    qn;

  state_t                        state;
  rmh_pkg::op_t                  op;
  logic signed [SAMPLE_BITS-1:0] smp;
  logic                          lo_push, lo_rep, up_push, up_rep, clr;
  logic signed [SAMPLE_BITS-1:0] lo_val, up_val;
  logic                          lo_busy, up_busy;
  logic signed [SAMPLE_BITS-1:0] lo_top, up_top;
  logic signed [SAMPLE_BITS-1:0] lo_tv, up_tv;
  logic [CW-1:0]                 lo_cnt, up_cnt;
  logic signed [SAMPLE_BITS:0]   sum;
  logic signed [SAMPLE_BITS:0]   half;

  assign q_ready = qn < 2'(rmh_pkg::QUEUE_DEPTH);
  assign idle    = (qn == '0) && (state == S_TAKE);

  rmh_heap #(.HEAP_DEPTH(HEAP_DEPTH), .SAMPLE_BITS(SAMPLE_BITS), .IS_MAX(1'b1)) u_lo (
    .clk, .rst, .clear(clr), .push(lo_push), .replace(lo_rep), .value(lo_val),
    .busy(lo_busy), .top(lo_top), .count(lo_cnt));
  rmh_heap #(.HEAP_DEPTH(HEAP_DEPTH), .SAMPLE_BITS(SAMPLE_BITS), .IS_MAX(1'b0)) u_up (
    .clk, .rst, .clear(clr), .push(up_push), .replace(up_rep), .value(up_val),
    .busy(up_busy), .top(up_top), .count(up_cnt));

  // an empty heap counts as zero
  assign lo_tv = (lo_cnt != '0) ? lo_top : '0;
  assign up_tv = (up_cnt != '0) ? up_top : '0;
  assign sum  = (SAMPLE_BITS+1)'(lo_tv) + (SAMPLE_BITS+1)'(up_tv);
  assign half = (sum + (SAMPLE_BITS+1)'(sum[SAMPLE_BITS])) >>> 1;

  always_comb begin
    clr = 1'b0; lo_push = 1'b0; lo_rep = 1'b0; up_push = 1'b0; up_rep = 1'b0;
    lo_val = smp; up_val = smp;
    case (state)
      S_TAKE: clr = (qn != '0) && qc[qrp];
      S_OP1: begin
        case (op)
          rmh_pkg::OP_PUSH_UP, rmh_pkg::OP_UP_MEAN: up_push = 1'b1;
          rmh_pkg::OP_PUSH_LO, rmh_pkg::OP_LO_MEAN: lo_push = 1'b1;
          rmh_pkg::OP_MV_LO_UP: begin up_push = 1'b1; up_val = lo_top; end
          rmh_pkg::OP_MV_UP_LO: begin lo_push = 1'b1; lo_val = up_top; end
          default: ;
        endcase
      end
      S_OP2: begin
        case (op)
          rmh_pkg::OP_MV_LO_UP: lo_rep = 1'b1;
          rmh_pkg::OP_MV_UP_LO: up_rep = 1'b1;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      qwp <= '0; qrp <= '0; qn <= '0;
      state <= S_TAKE;
      median <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      if (q_valid) begin
        qo[qwp] <= q_op; qc[qwp] <= q_clear; qs[qwp] <= q_sample;
        qwp <= ~qwp;
      end
      qn <= qn + 2'(q_valid) - 2'(state == S_TAKE && qn != '0);
      case (state)
        S_TAKE: begin
          if (qn != '0) begin
            op <= qo[qrp]; smp <= qs[qrp]; qrp <= ~qrp;
            if (qc[qrp]) median <= '0;
            state <= S_OP1;
          end
        end
        S_OP1:   state <= S_WAIT1;
        S_WAIT1: if (!lo_busy && !up_busy) state <= S_OP2;
        S_OP2:   state <= S_WAIT2;
        S_WAIT2: if (!lo_busy && !up_busy) state <= S_RES;
        S_RES: begin
          case (op)
            rmh_pkg::OP_PUSH_UP: median <= up_top;
            rmh_pkg::OP_PUSH_LO: median <= lo_top;
            rmh_pkg::OP_OVERFLOW: ;
            default: median <= half[SAMPLE_BITS-1:0];
          endcase
          out_ch.overflow <= (op == rmh_pkg::OP_OVERFLOW);
          out_ch.valid <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: if (out_ch.ready) begin
          out_ch.valid <= 1'b0;
          state <= S_TAKE;
        end
        default: state <= S_TAKE;
      endcase
    end
  end

  assign out_ch.median_out = median;
  assign out_ch.sample     = '0;
  assign out_ch.start_new  = 1'b0;

endmodule

// ----- design/running_median_two_heaps_top.sv -----
// channel | dir | payload
// in_ch   | in  | sample, start_new
// out_ch  | out | median_out, overflow
// a word's push sifts up and, for a move, a top replace then sifts down,
// over a registered-read memory per heap
// one word in flight; next word accepted after the result is taken
// reset clears counts, median and control; heap memories need no clearing
module running_median_two_heaps_top #(
  parameter int unsigned HEAP_DEPTH  = rmh_pkg::HEAP_DEPTH_DEF,
  parameter int unsigned SAMPLE_BITS = rmh_pkg::SAMPLE_BITS_DEF
) (
  input logic         clk,
  input logic         rst,
  rmh_stream_if.sink   in_ch,
  rmh_stream_if.source out_ch
);

  logic                          q_valid, q_ready, q_clear, back_idle;
  rmh_pkg::op_t                  q_op;
  logic signed [SAMPLE_BITS-1:0] q_sample;
  logic signed [SAMPLE_BITS-1:0] median;

  rmh_front #(.HEAP_DEPTH(HEAP_DEPTH), .SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk, .rst, .in_ch, .back_idle, .median, .q_valid, .q_op, .q_clear,
    .q_sample, .q_ready);

  rmh_back #(.HEAP_DEPTH(HEAP_DEPTH), .SAMPLE_BITS(SAMPLE_BITS)) u_back (
    .clk, .rst, .q_valid, .q_op, .q_clear, .q_sample, .q_ready,
    .idle(back_idle), .median, .out_ch);

endmodule

// ----- design/rmh_checker.sv -----
`include "running_median_two_heaps_top_macros.svh"
module rmh_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);
  `RMH_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid, "result dropped")
  `RMH_ASSERT_IMPL(a_no_take_busy, clk, rst, out_valid, !in_ready, "took word with result pending")
  `RMH_ASSERT_NEXT(a_no_early, clk, rst, in_valid && in_ready, !out_valid, "result too early")
endmodule

bind running_median_two_heaps_top rmh_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready));

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

  localparam int DEPTH = rmh_pkg::HEAP_DEPTH_DEF;
  localparam int SBITS = rmh_pkg::SAMPLE_BITS_DEF;

  typedef struct packed {
    logic signed [SBITS-1:0] median;
    logic                    overflow;
  } median_word_t;

  logic clk;
  logic rst;

  rmh_stream_if #(.SAMPLE_BITS(SBITS)) in_ch ();
  rmh_stream_if #(.SAMPLE_BITS(SBITS)) out_ch ();

  running_median_two_heaps_top #(
    .HEAP_DEPTH (DEPTH),
    .SAMPLE_BITS(SBITS)
  ) u_top (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // predictor state
  int lo_heap [DEPTH];
  int up_heap [DEPTH];
  int lo_cnt;
  int up_cnt;
  int cur_median;

  median_word_t medians_due[$];
  int mismatches;
  int results_seen;
  int overflows_seen;
  int items_sent;
  int stall_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit ranks_above(int a, int b, bit is_max);
    return is_max ? (a > b) : (a < b);
  endfunction

  task automatic heap_push(ref int h [DEPTH], ref int cnt, input int v, input bit is_max);
    int i;
    int p;
    int t;
    i = cnt;
    if (i >= DEPTH) return;
    h[i] = v;
    cnt = i + 1;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (!ranks_above(h[i], h[p], is_max)) break;
      t = h[i];
      h[i] = h[p];
      h[p] = t;
      i = p;
    end
  endtask

  task automatic heap_pop(ref int h [DEPTH], ref int cnt, input bit is_max);
    int n;
    int i;
    int l;
    int r;
    int best;
    int t;
    n = cnt;
    i = 0;
    if (n == 0) return;
    n--;
    h[0] = h[n];
    cnt = n;
    forever begin
      l = 2 * i + 1;
      r = l + 1;
      best = i;
      if (l < n && ranks_above(h[l], h[best], is_max)) best = l;
      if (r < n && ranks_above(h[r], h[best], is_max)) best = r;
      if (best == i) break;
      t = h[i];
      h[i] = h[best];
      h[best] = t;
      i = best;
    end
  endtask

  function automatic int mean_of_tops();
    int a;
    int b;
    a = lo_cnt ? lo_heap[0] : 0;
    b = up_cnt ? up_heap[0] : 0;
    return (a + b) / 2;
  endfunction

  task automatic predict_median(input logic signed [SBITS-1:0] sample, input logic start_new);
    int x;
    int m;
    bit goes_up;
    median_word_t w;
    x = sample;
    w.overflow = 1'b0;
    if (start_new) begin
      lo_cnt = 0;
      up_cnt = 0;
      cur_median = 0;
    end
    goes_up = x > cur_median;
    if (lo_cnt == up_cnt) begin
      if (goes_up) begin
        if (up_cnt >= DEPTH) w.overflow = 1'b1;
        else begin
          heap_push(up_heap, up_cnt, x, 1'b0);
          cur_median = up_heap[0];
        end
      end else begin
        if (lo_cnt >= DEPTH) w.overflow = 1'b1;
        else begin
          heap_push(lo_heap, lo_cnt, x, 1'b1);
          cur_median = lo_heap[0];
        end
      end
    end else if (lo_cnt > up_cnt) begin
      if (up_cnt >= DEPTH) w.overflow = 1'b1;
      else begin
        if (goes_up) heap_push(up_heap, up_cnt, x, 1'b0);
        else begin
          m = lo_heap[0];
          heap_push(up_heap, up_cnt, m, 1'b0);
          heap_pop(lo_heap, lo_cnt, 1'b1);
          heap_push(lo_heap, lo_cnt, x, 1'b1);
        end
        cur_median = mean_of_tops();
      end
    end else begin
      if (lo_cnt >= DEPTH) w.overflow = 1'b1;
      else begin
        if (goes_up) begin
          m = up_heap[0];
          heap_push(lo_heap, lo_cnt, m, 1'b1);
          heap_pop(up_heap, up_cnt, 1'b0);
          heap_push(up_heap, up_cnt, x, 1'b0);
        end else begin
          heap_push(lo_heap, lo_cnt, x, 1'b1);
        end
        cur_median = mean_of_tops();
      end
    end
    w.median = cur_median[SBITS-1:0];
    medians_due.insert(medians_due.size(), w);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // sends one word; called just after a falling edge
  task automatic send_sample(input logic signed [SBITS-1:0] sample, input logic start_new);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.sample    <= sample;
    in_ch.start_new <= start_new;
    do @(posedge clk); while (!in_ch.ready);
    predict_median(sample, start_new);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic finish_sending();
    in_ch.valid <= 1'b0;
  endtask

  function automatic logic signed [SBITS-1:0] draw_sample();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 15) - 8;
      1: return ($urandom_range(0, 1) ? 16'sh7fff : 16'sh8000);
      default: return $urandom;
    endcase
  endfunction

  // result checker with random and long hold-offs
  initial begin
    int gap;
    median_word_t want;
    out_ch.ready <= 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (stall_cycles > 0) begin
        out_ch.ready <= 1'b0;
        while (stall_cycles > 0) begin
          @(negedge clk);
          stall_cycles--;
        end
      end
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      results_seen++;
      if (medians_due.size() == 0) begin
        report_mismatch("unexpected word, median", out_ch.median_out, 0);
      end else begin
        want = medians_due.pop_front();
        if (out_ch.median_out !== want.median)
          report_mismatch("median_out", out_ch.median_out, want.median);
        if (out_ch.overflow !== want.overflow)
          report_mismatch("overflow", out_ch.overflow, want.overflow);
        if (want.overflow) overflows_seen++;
      end
      @(negedge clk);
    end
  end

  task automatic test_directed();
    send_sample(16'sd0, 1'b1);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(-16'sd3, 1'b1);
    send_sample(16'sd0, 1'b0);
    send_sample(-16'sd1, 1'b0);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sd5, 1'b0);
    send_sample(16'sd5, 1'b0);
    send_sample(16'sd5, 1'b1);
    send_sample(16'sd5, 1'b0);
    send_sample(16'sd5, 1'b0);
    send_sample(16'sd4, 1'b0);
    send_sample(16'sd6, 1'b0);
    send_sample(16'sh7fff, 1'b1);
    send_sample(16'sh7fff, 1'b0);
    send_sample(-16'sd7, 1'b0);
    send_sample(16'sd8, 1'b0);
  endtask

  // runs past both heaps holding the full depth
  task automatic test_heap_full();
    send_sample(draw_sample(), 1'b1);
    repeat (2 * DEPTH + 12) send_sample(draw_sample(), 1'b0);
  endtask

  task automatic test_random();
    repeat (640) send_sample(draw_sample(), $urandom_range(0, 39) == 0);
  endtask

  task automatic test_backpressure();
    stall_cycles = 400;
    repeat (30) send_sample(draw_sample(), $urandom_range(0, 9) == 0);
  endtask

  initial begin
    #20ms;
    $display("timeout at %0t", $realtime);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    lo_cnt = 0;
    up_cnt = 0;
    cur_median = 0;
    mismatches = 0;
    results_seen = 0;
    overflows_seen = 0;
    items_sent = 0;
    stall_cycles = 0;
    rst <= 1'b1;
    in_ch.valid      <= 1'b0;
    in_ch.sample     <= '0;
    in_ch.start_new  <= 1'b0;
    in_ch.median_out <= '0;
    in_ch.overflow   <= 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_heap_full();
    test_backpressure();
    test_random();
    finish_sending();
    while (medians_due.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("sent %0d samples, checked %0d medians, %0d of them overflow drops",
             items_sent, results_seen, overflows_seen);
    $display("covered field extremes, ties, restarts, full heaps and a long output stall");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
